### rtl/core/lrukpr_pkg.sv
// Shared constants and types for the LRU-K page replacement block.
package lrukpr_pkg;

   localparam int unsigned TABLE_ENTRIES = 1024;
   localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int unsigned CNT_W         = IDX_W + 1;
   localparam int unsigned PAGE_W        = 32;
   localparam int unsigned TIME_W        = 32;
   localparam int unsigned LIMIT_W       = 11;
   localparam int unsigned REFS_W        = 2;
   // history depth K: one older time plus the latest
   localparam logic [REFS_W-1:0] HISTORY_DEPTH = 2'd2;
   localparam logic [LIMIT_W-1:0] FRAME_LIMIT_RESET = 11'd4;

   // One entry of the tag table
   typedef struct packed {
      logic [PAGE_W-1:0] tag;
      logic [TIME_W-1:0] latest;
      logic [TIME_W-1:0] older;
      logic [REFS_W-1:0] refs;
      logic              res;
   } entry_type;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_SRD  = 8'b0000_0010,
      ST_SCMP = 8'b0000_0100,
      ST_UPD  = 8'b0000_1000,
      ST_VRD  = 8'b0001_0000,
      ST_VCMP = 8'b0010_0000,
      ST_VWR  = 8'b0100_0000,
      ST_EWR  = 8'b1000_0000
   } state_type;

   // Time of the K-th most recent reference, first one if fewer
   function automatic logic [TIME_W-1:0] kth_time(input entry_type ent);
      kth_time = (ent.refs <= 2'd1) ? ent.latest : ent.older;
   endfunction

endpackage

### rtl/core/lru_k_page_replacement.sv
// Top level of the LRU-K page replacement engine.
//
// Usage: pulse start with req_page_number while busy is low; the access is
// taken at that edge. One result transaction follows: rsp_valid is high for
// exactly one cycle with rsp_fault, rsp_evicted, rsp_victim_page,
// rsp_dropped and rsp_fault_total. The receiver cannot stall; busy stays
// high from acceptance until the cycle rsp_valid is shown, and the next
// start may be accepted in that same cycle.
// Sequence: the tag search reads the table one entry at a time (ST_SRD,
// then ST_SCMP); a hit or a new entry goes to ST_UPD, and a fault at the
// frame limit adds a victim scan (ST_VRD, ST_VCMP) over every entry in use.
// The entries sit in one table memory with a registered read and a
// separate write port.
// csr_wr_en/csr_wr_data write frame_limit; write it only while idle.
// Reset (synchronous, active high) clears tick, fault count, occupancy and
// the fill count, and sets frame_limit to 4. The table needs no clearing
// pass: only entries below the fill count are ever used.
module lru_k_page_replacement (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_page_number,
   input  logic        csr_wr_en,
   input  logic [10:0] csr_wr_data,
   output logic        rsp_valid,
   output logic        rsp_fault,
   output logic        rsp_evicted,
   output logic [31:0] rsp_victim_page,
   output logic        rsp_dropped,
   output logic [31:0] rsp_fault_total
);

   localparam int unsigned IW = lrukpr_pkg::IDX_W;
   localparam int unsigned CW = lrukpr_pkg::CNT_W;

   lrukpr_pkg::state_type  state_ff, state_in;
   logic [lrukpr_pkg::LIMIT_W-1:0] limit_ff;
   logic [31:0]            tick_ff, tick_in;
   logic [31:0]            faults_ff, faults_in;
   logic [CW-1:0]          used_ff, used_in;
   logic [CW-1:0]          frames_ff, frames_in;
   logic [CW-1:0]          scan_ff, scan_in;
   logic [31:0]            page_ff, page_in;
   logic [IW-1:0]          eidx_ff, eidx_in;
   lrukpr_pkg::entry_type  ent_ff, ent_in;
   logic                   have_ff, have_in;
   logic [IW-1:0]          bidx_ff, bidx_in;
   lrukpr_pkg::entry_type  best_ff, best_in;
   logic [31:0]            bage_ff, bage_in;

   logic                   rv_ff, rv_in;
   logic                   rf_ff, rf_in;
   logic                   re_ff, re_in;
   logic [31:0]            rvp_ff, rvp_in;
   logic                   rd_ff, rd_in;
   logic [31:0]            rft_ff, rft_in;

   // table memory
   lrukpr_pkg::entry_type  mem [lrukpr_pkg::TABLE_ENTRIES];
   lrukpr_pkg::entry_type  rdata_ff;
   logic                   mem_we;
   logic [IW-1:0]          mem_waddr;
   lrukpr_pkg::entry_type  mem_wdata;
   logic [IW-1:0]          mem_raddr;

   logic [CW-1:0]          scan_nxt;
   logic [31:0]            age;

   assign scan_nxt  = scan_ff + 1'b1;
   assign mem_raddr = scan_ff[IW-1:0];
   assign age       = tick_ff - lrukpr_pkg::kth_time(rdata_ff);

   // Write and read the table
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   // Sequence one access
   always_comb begin
      state_in  = state_ff;
      tick_in   = tick_ff;
      faults_in = faults_ff;
      used_in   = used_ff;
      frames_in = frames_ff;
      scan_in   = scan_ff;
      page_in   = page_ff;
      eidx_in   = eidx_ff;
      ent_in    = ent_ff;
      have_in   = have_ff;
      bidx_in   = bidx_ff;
      best_in   = best_ff;
      bage_in   = bage_ff;
      rv_in     = 1'b0;
      rf_in     = rf_ff;
      re_in     = re_ff;
      rvp_in    = rvp_ff;
      rd_in     = rd_ff;
      rft_in    = rft_ff;
      mem_we    = 1'b0;
      mem_waddr = eidx_ff;
      mem_wdata = ent_ff;
      case (state_ff)
         lrukpr_pkg::ST_IDLE: begin
            if (start) begin
               tick_in = tick_ff + 32'd1;
               page_in = req_page_number;
               scan_in = '0;
               state_in = lrukpr_pkg::ST_SRD;
            end
         end
         lrukpr_pkg::ST_SRD: begin
            // empty table or search done: allocate or drop
            if (scan_ff == used_ff) begin
               if (used_ff < CW'(lrukpr_pkg::TABLE_ENTRIES)) begin
                  eidx_in    = used_ff[IW-1:0];
                  used_in    = used_ff + 1'b1;
                  ent_in     = '0;
                  ent_in.tag = page_ff;
                  state_in   = lrukpr_pkg::ST_UPD;
               end else begin
                  rv_in  = 1'b1;
                  rf_in  = 1'b0;
                  re_in  = 1'b0;
                  rvp_in = '0;
                  rd_in  = 1'b1;
                  rft_in = faults_ff;
                  state_in = lrukpr_pkg::ST_IDLE;
               end
            end else begin
               state_in = lrukpr_pkg::ST_SCMP;
            end
         end
         lrukpr_pkg::ST_SCMP: begin
            if (rdata_ff.tag == page_ff) begin
               eidx_in  = scan_ff[IW-1:0];
               ent_in   = rdata_ff;
               state_in = lrukpr_pkg::ST_UPD;
            end else begin
               scan_in  = scan_nxt;
               state_in = lrukpr_pkg::ST_SRD;
            end
         end
         lrukpr_pkg::ST_UPD: begin
            // record the reference
            ent_in.older  = ent_ff.latest;
            ent_in.latest = tick_ff;
            if (ent_ff.refs < lrukpr_pkg::HISTORY_DEPTH) begin
               ent_in.refs = ent_ff.refs + 2'd1;
            end
            rf_in  = !ent_ff.res;
            re_in  = 1'b0;
            rvp_in = '0;
            rd_in  = 1'b0;
            if (ent_ff.res) begin
               mem_we    = 1'b1;
               mem_wdata = ent_in;
               rv_in     = 1'b1;
               rft_in    = faults_ff;
               state_in  = lrukpr_pkg::ST_IDLE;
            end else begin
               if (faults_ff != 32'hFFFF_FFFF) begin
                  faults_in = faults_ff + 32'd1;
               end
               have_in = 1'b0;
               scan_in = '0;
               if (frames_ff >= CW'(limit_ff)) begin
                  state_in = lrukpr_pkg::ST_VRD;
               end else begin
                  state_in = lrukpr_pkg::ST_EWR;
               end
            end
         end
         lrukpr_pkg::ST_VRD: begin
            state_in = lrukpr_pkg::ST_VCMP;
         end
         lrukpr_pkg::ST_VCMP: begin
            // keep the oldest resident entry, lowest index on ties
            if (rdata_ff.res && (scan_ff[IW-1:0] != eidx_ff)
                && (!have_ff || (age > bage_ff))) begin
               have_in = 1'b1;
               bidx_in = scan_ff[IW-1:0];
               best_in = rdata_ff;
               bage_in = age;
            end
            scan_in = scan_nxt;
            if (scan_nxt == used_ff) begin
               state_in = have_in ? lrukpr_pkg::ST_VWR : lrukpr_pkg::ST_EWR;
            end else begin
               state_in = lrukpr_pkg::ST_VRD;
            end
         end
         lrukpr_pkg::ST_VWR: begin
            mem_we        = 1'b1;
            mem_waddr     = bidx_ff;
            mem_wdata     = best_ff;
            mem_wdata.res = 1'b0;
            frames_in     = frames_ff - 1'b1;
            re_in         = 1'b1;
            rvp_in        = best_ff.tag;
            state_in      = lrukpr_pkg::ST_EWR;
         end
         lrukpr_pkg::ST_EWR: begin
            mem_we        = 1'b1;
            mem_wdata     = ent_ff;
            mem_wdata.res = 1'b1;
            frames_in     = frames_ff + 1'b1;
            rv_in         = 1'b1;
            rft_in        = faults_ff;
            state_in      = lrukpr_pkg::ST_IDLE;
         end
         default: begin
            state_in = lrukpr_pkg::ST_IDLE;
         end
      endcase
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= lrukpr_pkg::ST_IDLE;
         limit_ff  <= lrukpr_pkg::FRAME_LIMIT_RESET;
         tick_ff   <= '0;
         faults_ff <= '0;
         used_ff   <= '0;
         frames_ff <= '0;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         tick_ff   <= tick_in;
         faults_ff <= faults_in;
         used_ff   <= used_in;
         frames_ff <= frames_in;
         rv_ff     <= rv_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   // Advance payload registers
   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      page_ff <= page_in;
      eidx_ff <= eidx_in;
      ent_ff  <= ent_in;
      have_ff <= have_in;
      bidx_ff <= bidx_in;
      best_ff <= best_in;
      bage_ff <= bage_in;
      rf_ff   <= rf_in;
      re_ff   <= re_in;
      rvp_ff  <= rvp_in;
      rd_ff   <= rd_in;
      rft_ff  <= rft_in;
   end

   assign busy            = (state_ff != lrukpr_pkg::ST_IDLE);
   assign rsp_valid       = rv_ff;
   assign rsp_fault       = rf_ff;
   assign rsp_evicted     = re_ff;
   assign rsp_victim_page = rvp_ff;
   assign rsp_dropped     = rd_ff;
   assign rsp_fault_total = rft_ff;

   // Checks
   a_frames_le_used: assert property (@(posedge clock) disable iff (reset)
      frames_ff <= used_ff)
      else $error("more frames resident than entries allocated");
   a_evict_needs_fault: assert property (@(posedge clock) disable iff (reset)
      rv_ff && re_ff |-> rf_ff && !rd_ff)
      else $error("eviction without a fault");
   a_drop_no_fault: assert property (@(posedge clock) disable iff (reset)
      rv_ff && rd_ff |-> !rf_ff && !re_ff)
      else $error("dropped transaction flagged as fault");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");

endmodule
